### hw/rtl/gso_pkg.sv
// gram-schmidt orthonormalizer package: sizes, fixed-point widths, memory request type
// depends on nothing
`timescale 1ns / 1ps
package gso_pkg;

  localparam int MAX_VECTORS   = 8;
  localparam int MAX_DIMENSION = 8;
  localparam int VEC_W   = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
  localparam int DIM_W   = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
  localparam int DEPTH   = MAX_VECTORS * MAX_DIMENSION;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORK_W  = 32;  // working values, q.24
  localparam int NUM_W   = 55;  // divider numerator: |v| << 24 plus half the norm
  localparam int ROOT_W  = 32;  // norm
  localparam int CFG_W   = 4;

  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [WORK_W-1:0] wdata;
    logic [ADDR_W-1:0]        raddr_a;
    logic [ADDR_W-1:0]        raddr_b;
  } mem_req_t;

endpackage

### hw/rtl/gram_schmidt_orthonormalizer.sv
// top level: load sequencer, modified gram-schmidt sequencer, output register
// depends on gso_pkg, gso_vmem, gso_sqrt, gso_div
`timescale 1ns / 1ps
// Takes n*d components (Q4.12) on the slave stream, one per cycle while
// s_axis_tready_o is high, vector by vector, into a 64-entry vector store.
// The request that brings the final component starts the orthonormalization,
// which runs from the store through one shared multiplier: each projection is a
// dot product, then a subtract, each norm a sum of squares and a square root,
// and each component is divided in the bit-serial divider; a zero vector is
// cleared. The basis then streams out as Q2.14, one result at a time, the next
// only once the output register is free. Input is not taken from the last load
// until the final result sits in the output register. vector_count and
// dimension are written only between sets, a rule for the user that the block
// does not enforce; a write restarts loading at the first component. Out-of-range
// settings clamp to 1..8. A degenerate vector is all zeros with tuser set.
module gram_schmidt_orthonormalizer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [gso_pkg::CFG_W-1:0] cfg_data_i,
  input  logic [15:0]               s_axis_tdata_i,   // component
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  output logic [23:0]               m_axis_tdata_o,   // basis_component, vector_index,
                                                      // component_index, zero fill
  output logic                      m_axis_tuser_o,   // degenerate
  output logic                      m_axis_tlast_o,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i
);
  import gso_pkg::*;

  localparam logic CFG_VEC_COUNT = 1'b0;
  localparam logic CFG_DIMENSION = 1'b1;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_NEXT   = 11'b00000000010,
    ST_DOT    = 11'b00000000100,
    ST_DOTR   = 11'b00000001000,
    ST_SUB    = 11'b00000010000,
    ST_SQS    = 11'b00000100000,
    ST_SQRT   = 11'b00001000000,
    ST_ZERO   = 11'b00010000000,
    ST_DIV    = 11'b00100000000,
    ST_OUT_RD = 11'b01000000000,
    ST_OUT_WR = 11'b10000000000
  } state_e;

  localparam logic signed [41:0] WORK_MAX = 42'sd1073741823;

  // round a q.48 value to q.24, half away from zero
  function automatic logic signed [40:0] rnd24(input logic signed [63:0] x);
    logic [63:0] mag;
    logic [39:0] m;
    mag = x[63] ? (64'd0 - 64'(x)) : 64'(x);
    m   = 40'((mag + 64'd8388608) >> 24);
    rnd24 = x[63] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic [ADDR_W-1:0] addr(input logic [VEC_W-1:0] v,
                                             input logic [DIM_W-1:0] c);
    addr = ADDR_W'(int'(v) * MAX_DIMENSION + int'(c));
  endfunction

  function automatic logic [VEC_W-1:0] clamp_n(input logic [CFG_W-1:0] raw);
    int r;
    r = int'(raw);
    if (r < 1) r = 1;
    if (r > MAX_VECTORS) r = MAX_VECTORS;
    clamp_n = VEC_W'(r - 1);
  endfunction

  function automatic logic [DIM_W-1:0] clamp_d(input logic [CFG_W-1:0] raw);
    int r;
    r = int'(raw);
    if (r < 1) r = 1;
    if (r > MAX_DIMENSION) r = MAX_DIMENSION;
    clamp_d = DIM_W'(r - 1);
  endfunction

  state_e state_q, state_d;
  logic [VEC_W-1:0] n_m1_q, n_m1_d, lv_q, lv_d, vi_q, vi_d, vj_q, vj_d;
  logic [DIM_W-1:0] d_m1_q, d_m1_d, lc_q, lc_d, cc_q, cc_d;
  logic [1:0]       ph_q, ph_d;
  logic [MAX_VECTORS-1:0] degen_q, degen_d;
  logic signed [63:0] acc_q, acc_d, prod_q, prod_d, acc_sum;
  logic signed [35:0] dot_q, dot_d;
  logic signed [WORK_W-1:0] vw_q, vw_d;
  logic [ROOT_W-1:0] norm_q, norm_d;

  // output register
  logic        m_valid_q, m_valid_d;
  logic [15:0] m_comp_q, m_comp_d;
  logic [2:0]  m_vi_q, m_vi_d, m_ci_q, m_ci_d;
  logic        m_deg_q, m_deg_d, m_last_q, m_last_d;

  mem_req_t req;
  logic signed [WORK_W-1:0] rd_a, rd_b;

  // shared multiplier
  logic signed [35:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [67:0] mul_p;

  logic              sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num;
  logic [WORK_W-1:0] div_quo;

  logic [WORK_W-1:0] rda_mag;
  logic signed [41:0] diff;
  logic signed [WORK_W-1:0] sub_val;
  logic [WORK_W-1:0] out_mag;
  logic [22:0]       out_m;
  logic [15:0]       out_val;

  assign mul_p   = mul_a * mul_b;
  assign acc_sum = acc_q + prod_q;
  assign rda_mag = rd_a[WORK_W-1] ? (WORK_W'(0) - WORK_W'(rd_a)) : WORK_W'(rd_a);
  assign div_num = (NUM_W'(rda_mag) << 24) + NUM_W'(norm_q >> 1);

  // subtract the projection term and saturate the working value
  always_comb begin
    diff = 42'(vw_q) - 42'(rnd24(prod_q));
    if (diff > WORK_MAX) begin
      sub_val = WORK_W'(WORK_MAX);
    end else if (diff < -WORK_MAX) begin
      sub_val = WORK_W'(-WORK_MAX);
    end else begin
      sub_val = WORK_W'(diff);
    end
  end

  // q.24 to q2.14, half away from zero, saturated
  always_comb begin
    out_mag = rd_a[WORK_W-1] ? (WORK_W'(0) - WORK_W'(rd_a)) : WORK_W'(rd_a);
    out_m   = 23'((out_mag + 32'd512) >> 10);
    if (rd_a[WORK_W-1]) begin
      out_val = (out_m > 23'd32768) ? 16'h8000 : 16'(23'd0 - out_m);
    end else begin
      out_val = (out_m > 23'd32767) ? 16'h7fff : out_m[15:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    n_m1_d    = n_m1_q;
    d_m1_d    = d_m1_q;
    lv_d      = lv_q;
    lc_d      = lc_q;
    vi_d      = vi_q;
    vj_d      = vj_q;
    cc_d      = cc_q;
    ph_d      = ph_q;
    degen_d   = degen_q;
    acc_d     = acc_q;
    prod_d    = prod_q;
    dot_d     = dot_q;
    vw_d      = vw_q;
    norm_d    = norm_q;
    m_valid_d = m_valid_q;
    m_comp_d  = m_comp_q;
    m_vi_d    = m_vi_q;
    m_ci_d    = m_ci_q;
    m_deg_d   = m_deg_q;
    m_last_d  = m_last_q;
    req        = '0;
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          req.we    = 1'b1;
          req.waddr = addr(lv_q, lc_q);
          req.wdata = {{4{s_axis_tdata_i[15]}}, s_axis_tdata_i, 12'd0};
          if (lc_q == d_m1_q) begin
            lc_d = '0;
            if (lv_q == n_m1_q) begin
              lv_d    = '0;
              vi_d    = '0;
              vj_d    = '0;
              degen_d = '0;
              state_d = ST_NEXT;
            end else begin
              lv_d = lv_q + 1'b1;
            end
          end else begin
            lc_d = lc_q + 1'b1;
          end
        end
      end
      ST_NEXT: begin
        acc_d   = '0;
        cc_d    = '0;
        ph_d    = '0;
        state_d = (vj_q < vi_q) ? ST_DOT : ST_SQS;
      end
      ST_DOT: begin
        case (ph_q)
          2'd0: begin
            req.raddr_a = addr(vi_q, cc_q);
            req.raddr_b = addr(vj_q, cc_q);
            ph_d = 2'd1;
          end
          2'd1: begin
            mul_a  = 36'(rd_a);
            mul_b  = rd_b;
            prod_d = mul_p[63:0];
            ph_d   = 2'd2;
          end
          default: begin
            acc_d = acc_sum;
            ph_d  = 2'd0;
            if (cc_q == d_m1_q) begin
              cc_d    = '0;
              state_d = ST_DOTR;
            end else begin
              cc_d = cc_q + 1'b1;
            end
          end
        endcase
      end
      ST_DOTR: begin
        dot_d   = 36'(rnd24(acc_q));
        state_d = ST_SUB;
      end
      ST_SUB: begin
        case (ph_q)
          2'd0: begin
            req.raddr_a = addr(vi_q, cc_q);
            req.raddr_b = addr(vj_q, cc_q);
            ph_d = 2'd1;
          end
          2'd1: begin
            mul_a  = dot_q;
            mul_b  = rd_b;
            prod_d = mul_p[63:0];
            vw_d   = rd_a;
            ph_d   = 2'd2;
          end
          default: begin
            req.we    = 1'b1;
            req.waddr = addr(vi_q, cc_q);
            req.wdata = sub_val;
            ph_d      = 2'd0;
            if (cc_q == d_m1_q) begin
              vj_d    = vj_q + 1'b1;
              state_d = ST_NEXT;
            end else begin
              cc_d = cc_q + 1'b1;
            end
          end
        endcase
      end
      ST_SQS: begin
        case (ph_q)
          2'd0: begin
            req.raddr_a = addr(vi_q, cc_q);
            ph_d = 2'd1;
          end
          2'd1: begin
            mul_a  = 36'(rd_a);
            mul_b  = rd_a;
            prod_d = mul_p[63:0];
            ph_d   = 2'd2;
          end
          default: begin
            acc_d = acc_sum;
            ph_d  = 2'd0;
            if (cc_q == d_m1_q) begin
              cc_d    = '0;
              state_d = (acc_sum == 64'sd0) ? ST_ZERO : ST_SQRT;
            end else begin
              cc_d = cc_q + 1'b1;
            end
          end
        endcase
      end
      ST_SQRT: begin
        if (ph_q == 2'd0) begin
          sqrt_start = 1'b1;
          ph_d       = 2'd1;
        end else if (sqrt_done) begin
          norm_d  = sqrt_root;
          ph_d    = 2'd0;
          cc_d    = '0;
          state_d = ST_DIV;
        end
      end
      ST_ZERO: begin
        req.we         = 1'b1;
        req.waddr      = addr(vi_q, cc_q);
        req.wdata      = '0;
        degen_d[vi_q]  = 1'b1;
        if (cc_q == d_m1_q) begin
          cc_d = '0;
          if (vi_q == n_m1_q) begin
            vi_d    = '0;
            state_d = ST_OUT_RD;
          end else begin
            vi_d    = vi_q + 1'b1;
            vj_d    = '0;
            state_d = ST_NEXT;
          end
        end else begin
          cc_d = cc_q + 1'b1;
        end
      end
      ST_DIV: begin
        case (ph_q)
          2'd0: begin
            req.raddr_a = addr(vi_q, cc_q);
            ph_d = 2'd1;
          end
          2'd1: begin
            vw_d      = rd_a;
            div_start = 1'b1;
            ph_d      = 2'd2;
          end
          default: begin
            if (div_done) begin
              req.we    = 1'b1;
              req.waddr = addr(vi_q, cc_q);
              req.wdata = vw_q[WORK_W-1] ? $signed(WORK_W'(0) - div_quo) : $signed(div_quo);
              ph_d      = 2'd0;
              if (cc_q == d_m1_q) begin
                cc_d = '0;
                if (vi_q == n_m1_q) begin
                  vi_d    = '0;
                  state_d = ST_OUT_RD;
                end else begin
                  vi_d    = vi_q + 1'b1;
                  vj_d    = '0;
                  state_d = ST_NEXT;
                end
              end else begin
                cc_d = cc_q + 1'b1;
              end
            end
          end
        endcase
      end
      ST_OUT_RD: begin
        req.raddr_a = addr(vi_q, cc_q);
        if (!m_valid_q) begin
          state_d = ST_OUT_WR;
        end
      end
      ST_OUT_WR: begin
        m_valid_d = 1'b1;
        m_comp_d  = out_val;
        m_vi_d    = 3'(vi_q);
        m_ci_d    = 3'(cc_q);
        m_deg_d   = degen_q[vi_q];
        m_last_d  = (vi_q == n_m1_q) && (cc_q == d_m1_q);
        state_d   = ST_OUT_RD;
        if (cc_q == d_m1_q) begin
          cc_d = '0;
          if (vi_q == n_m1_q) begin
            vi_d    = '0;
            state_d = ST_IDLE;
          end else begin
            vi_d = vi_q + 1'b1;
          end
        end else begin
          cc_d = cc_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a register write restarts the load
    if (cfg_we_i) begin
      lv_d = '0;
      lc_d = '0;
      case (cfg_idx_i)
        CFG_VEC_COUNT: n_m1_d = clamp_n(cfg_data_i);
        CFG_DIMENSION: d_m1_d = clamp_d(cfg_data_i);
        default: n_m1_d = n_m1_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      n_m1_q    <= VEC_W'(MAX_VECTORS - 1);
      d_m1_q    <= DIM_W'(MAX_DIMENSION - 1);
      lv_q      <= '0;
      lc_q      <= '0;
      vi_q      <= '0;
      vj_q      <= '0;
      cc_q      <= '0;
      ph_q      <= '0;
      degen_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_m1_q    <= n_m1_d;
      d_m1_q    <= d_m1_d;
      lv_q      <= lv_d;
      lc_q      <= lc_d;
      vi_q      <= vi_d;
      vj_q      <= vj_d;
      cc_q      <= cc_d;
      ph_q      <= ph_d;
      degen_q   <= degen_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    dot_q    <= dot_d;
    vw_q     <= vw_d;
    norm_q   <= norm_d;
    m_comp_q <= m_comp_d;
    m_vi_q   <= m_vi_d;
    m_ci_q   <= m_ci_d;
    m_deg_q  <= m_deg_d;
    m_last_q <= m_last_d;
  end

  gso_vmem u_vmem (
    .clk_i  (clk_i),
    .req_i  (req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  gso_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (64'(acc_q)),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  gso_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (norm_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, m_ci_q, m_vi_q, m_comp_q};
  assign m_axis_tuser_o  = m_deg_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

### hw/rtl/gso_vmem.sv
// vector store: one write port, two registered read ports
// depends on gso_pkg
`timescale 1ns / 1ps
module gso_vmem (
  input  logic                              clk_i,
  input  gso_pkg::mem_req_t                 req_i,
  output logic signed [gso_pkg::WORK_W-1:0] rd_a_o,
  output logic signed [gso_pkg::WORK_W-1:0] rd_b_o
);
  import gso_pkg::*;

  logic signed [WORK_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_a_o <= mem_q[req_i.raddr_a];
    rd_b_o <= mem_q[req_i.raddr_b];
  end

endmodule

### hw/rtl/gso_sqrt.sv
// iterative integer square root, one result bit per pass
// depends on gso_pkg
`timescale 1ns / 1ps
module gso_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [63:0]                x_i,
  output logic                       done_o,
  output logic [gso_pkg::ROOT_W-1:0] root_o
);
  import gso_pkg::*;

  logic        busy_q, done_q;
  logic [63:0] x_q, res_q, bit_q;
  logic [63:0] sum;
  logic        ge;

  assign sum = res_q + bit_q;
  assign ge  = (x_q >= sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      res_q <= '0;
      bit_q <= {2'b01, 62'd0};
    end else if (busy_q) begin
      if (ge) begin
        x_q   <= x_q - sum;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

### hw/rtl/gso_div.sv
// restoring radix-2 divider, one quotient bit per cycle
// depends on gso_pkg
`timescale 1ns / 1ps
module gso_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gso_pkg::NUM_W-1:0]  num_i,
  input  logic [gso_pkg::ROOT_W-1:0] den_i,
  output logic                       done_o,
  output logic [gso_pkg::WORK_W-1:0] quo_o
);
  import gso_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [NUM_W-1:0]  num_q;
  logic [ROOT_W-1:0] den_q;
  logic [ROOT_W:0]   rem_q;
  logic [WORK_W-1:0] quo_q;
  logic [ROOT_W+1:0] trial;
  logic              ge;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = (trial >= {2'b00, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= ge ? (ROOT_W+1)'(trial - {2'b00, den_q}) : trial[ROOT_W:0];
      quo_q <= {quo_q[WORK_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### hw/rtl/gso_chk.sv
// port-level checks for the orthonormalizer, bound to the top level
// depends on gram_schmidt_orthonormalizer
`timescale 1ns / 1ps
module gso_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic [23:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // no new request while a set still drains
  a_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input ready during output phase");

  // degenerate vectors come out as zeros
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[15:0] == 16'd0)
    else $error("degenerate vector with nonzero component");

endmodule

bind gram_schmidt_orthonormalizer gso_chk u_gso_chk (.*);
